// ===== sv/cdfs_pkg.sv =====
// Shared types and constants of the CDF table inverse sampler.
// Used by the controller, the datapath and the top level; depends on nothing.
package cdfs_pkg;

	// Input item and result field widths
	localparam int INDEX_W    = 10;
	localparam int CDF_W      = 32;
	localparam int BIN_W      = 10;
	localparam int FRAC_OUT_W = 16;
	localparam int VALUE_W    = 52;

	// Configuration registers
	localparam int BASE_W     = 32;
	localparam int STEP_W     = 24;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 1;

	// Shared multiplier: bin step times bin number or quotient
	localparam int MUL_B_W = 32;
	localparam int MUL_W   = STEP_W + MUL_B_W;

	// Item command codes
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE_FREQUENCY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_STEP       = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic load;      // write a table entry from the input transfer
		logic start;     // take a sample item, issue first search read
		logic search;    // one binary search step
		logic rd_lo;     // capture lower entry, multiply bin by step
		logic rd_hi;     // capture upper entry, set up divider
		logic div_step;  // one quotient bit
		logic mul_frac;  // multiply quotient by step
		logic out_load;  // load the output register
	} cdfs_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic search_done;
		logic div_skip;
		logic div_last;
		logic out_free;
	} cdfs_sts_t;

endpackage

// ===== sv/cdfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cdfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== sv/cdfs_ctrl.sv =====
// Sequencing controller of the CDF table inverse sampler.
// Depends on cdfs_pkg for the command and status structs.
module cdfs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  cdfs_pkg::cdfs_sts_t sts,
	output cdfs_pkg::cdfs_cmd_t cmd
);

	import cdfs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_RD_LO,
		ST_RD_HI,
		ST_DIV,
		ST_MUL,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   xfer;

	assign in_ready = (state_q == ST_IDLE);
	assign xfer     = in_valid && in_ready;

	// Command decode
	always_comb begin
		cmd          = '0;
		cmd.load     = xfer && (command == CMD_LOAD);
		cmd.start    = xfer && (command == CMD_SAMPLE);
		cmd.search   = (state_q == ST_SEARCH);
		cmd.rd_lo    = (state_q == ST_RD_LO);
		cmd.rd_hi    = (state_q == ST_RD_HI);
		cmd.div_step = (state_q == ST_DIV);
		cmd.mul_frac = (state_q == ST_MUL);
		cmd.out_load = (state_q == ST_OUT) && sts.out_free;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (xfer && (command == CMD_SAMPLE)) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (sts.search_done) begin
						state_q <= ST_RD_LO;
					end
				end
				ST_RD_LO: begin
					state_q <= ST_RD_HI;
				end
				ST_RD_HI: begin
					state_q <= sts.div_skip ? ST_MUL : ST_DIV;
				end
				ST_DIV: begin
					if (sts.div_last) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/cdfs_dpath.sv =====
// Datapath of the CDF table inverse sampler: table RAM, search bounds,
// restoring divider, shared multiplier, config registers, output register.
// Depends on cdfs_pkg and cdfs_ram.
module cdfs_dpath #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cdfs_pkg::cdfs_cmd_t                  cmd,
	output cdfs_pkg::cdfs_sts_t                  sts,
	input  logic                                 cfg_write,
	input  logic [cdfs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cdfs_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [cdfs_pkg::INDEX_W-1:0]         entry_index,
	input  logic [cdfs_pkg::CDF_W-1:0]           cdf_value,
	input  logic [cdfs_pkg::CDF_W-1:0]           uniform_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [cdfs_pkg::BIN_W-1:0]           bin_number,
	output logic [cdfs_pkg::FRAC_OUT_W-1:0]      bin_fraction,
	output logic [cdfs_pkg::VALUE_W-1:0]         sampled_value
);

	import cdfs_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(FRACTION_BITS);
	localparam logic [AW-1:0] HI_INIT  = AW'(TABLE_ENTRIES - 1);
	localparam logic [AW-1:0] MID_INIT = AW'((TABLE_ENTRIES - 1) / 2);

	// Config registers
	logic [BASE_W-1:0] base_q;
	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			step_q <= STEP_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_BASE_FREQUENCY: base_q <= cfg_data[BASE_W-1:0];
				REG_BIN_STEP:       step_q <= cfg_data[STEP_W-1:0];
				default:            ;
			endcase
		end
	end

	// Table RAM
	logic          wr_en;
	logic [AW-1:0] rd_addr;
	logic [CDF_W-1:0] rd_data;

	assign wr_en = cmd.load && (32'(entry_index) < 32'(TABLE_ENTRIES));

	cdfs_ram #(
		.WIDTH(CDF_W),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(AW'(entry_index)),
		.wr_data(cdf_value),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Binary search: rd_data holds the entry at the midpoint of lo_q/hi_q
	logic [CDF_W-1:0] u_q;
	logic [AW-1:0]    lo_q, hi_q, lo_n, hi_n, mid_cur, mid_n;
	logic [AW:0]      sum_cur, sum_n;
	logic [AW-1:0]    span_n;

	assign sum_cur = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_cur = sum_cur[AW:1];

	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		if (u_q < rd_data) begin
			hi_n = mid_cur;
		end else begin
			lo_n = mid_cur;
		end
	end

	assign sum_n           = {1'b0, lo_n} + {1'b0, hi_n};
	assign mid_n           = sum_n[AW:1];
	assign span_n          = hi_n - lo_n;
	assign sts.search_done = (span_n <= AW'(1));

	// Read address select
	always_comb begin
		if (cmd.start) begin
			rd_addr = MID_INIT;
		end else if (cmd.search) begin
			rd_addr = sts.search_done ? lo_n : mid_n;
		end else begin
			rd_addr = hi_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			u_q  <= uniform_value;
			lo_q <= '0;
			hi_q <= HI_INIT;
		end else if (cmd.search) begin
			lo_q <= lo_n;
			hi_q <= hi_n;
		end
	end

	// Shared multiplier: step times bin, then step times quotient
	logic [FRACTION_BITS-1:0] quot_q;
	logic [MUL_B_W-1:0]       mul_b;
	logic [MUL_W-1:0]         product;
	logic [VALUE_W-1:0]       prod_bin_q, prod_frac_q;

	assign mul_b   = cmd.mul_frac ? MUL_B_W'(quot_q) : MUL_B_W'(lo_q);
	assign product = MUL_W'(step_q) * MUL_W'(mul_b);

	always_ff @(posedge clk) begin
		if (cmd.rd_lo) begin
			prod_bin_q <= VALUE_W'(product);
		end
		if (cmd.mul_frac) begin
			prod_frac_q <= VALUE_W'(product);
		end
	end

	// Bin edges and divider setup
	logic [CDF_W-1:0] lower_q;
	logic [CDF_W-1:0] rem_q, den_q, num, den;
	logic [CW-1:0]    cnt_q;
	logic             flat, below, sat;
	logic [CDF_W:0]   rem2;
	logic             ge;

	assign num   = u_q - lower_q;
	assign den   = rd_data - lower_q;
	assign flat  = (rd_data <= lower_q);
	assign below = (u_q <= lower_q);
	assign sat   = (num >= den);

	assign sts.div_skip = flat || below || sat;
	assign sts.div_last = (cnt_q == CW'(FRACTION_BITS - 1));

	// Restoring division, one quotient bit a cycle
	assign rem2 = {rem_q, 1'b0};
	assign ge   = (rem2 >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (cmd.rd_lo) begin
			lower_q <= rd_data;
		end
		if (cmd.rd_hi) begin
			rem_q  <= num;
			den_q  <= den;
			cnt_q  <= '0;
			quot_q <= (sat && !flat && !below) ? '1 : '0;
		end else if (cmd.div_step) begin
			rem_q  <= ge ? CDF_W'(rem2 - {1'b0, den_q}) : rem2[CDF_W-1:0];
			quot_q <= {quot_q[FRACTION_BITS-2:0], ge};
			cnt_q  <= cnt_q + CW'(1);
		end
	end

	// Grid value: base and step * bin scaled by the fraction width, plus step * fraction
	logic [VALUE_W-1:0] value;

	assign value = (VALUE_W'(base_q) << FRACTION_BITS)
		+ (prod_bin_q << FRACTION_BITS) + prod_frac_q;

	// Output register
	logic out_valid_q;

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			bin_number    <= BIN_W'(lo_q);
			bin_fraction  <= FRAC_OUT_W'(quot_q);
			sampled_value <= value;
		end
	end

endmodule

// ===== sv/cdf_table_inverse_sampler.sv =====
// Top level of the CDF table inverse sampler: controller plus datapath.
// Depends on cdfs_pkg, cdfs_ctrl, cdfs_dpath (and cdfs_ram below it).
//
// Load items (command 0) write one cumulative table entry; the block is
// ready again on the next cycle. Sample items (command 1) binary-search
// the table, one RAM read per step, then divide one quotient bit per
// cycle and scale onto the output grid. The search reads through the
// single table read port and the serial divider set how long a sample
// occupies the block. Some search paths take one step fewer than others.
// A flat or falling bin, a value at or below the lower entry, or a value
// at or above the upper entry skips the divide. A finished result sits in
// an output register, so the next item is taken while it waits; a sample
// that finishes while that register is still full waits until it is
// taken. The table has no reset: sample only after every entry the
// search may touch has been loaded. The user must write base_frequency
// and bin_step only while the block is idle; the block does not
// enforce this itself.
module cdf_table_inverse_sampler #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [cdfs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cdfs_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 command,
	input  logic [cdfs_pkg::INDEX_W-1:0]         entry_index,
	input  logic [cdfs_pkg::CDF_W-1:0]           cdf_value,
	input  logic [cdfs_pkg::CDF_W-1:0]           uniform_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [cdfs_pkg::BIN_W-1:0]           bin_number,
	output logic [cdfs_pkg::FRAC_OUT_W-1:0]      bin_fraction,
	output logic [cdfs_pkg::VALUE_W-1:0]         sampled_value
);

	import cdfs_pkg::*;

	cdfs_cmd_t cmd;
	cdfs_sts_t sts;

	cdfs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command (command),
		.sts     (sts),
		.cmd     (cmd)
	);

	cdfs_dpath #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.FRACTION_BITS(FRACTION_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.entry_index  (entry_index),
		.cdf_value    (cdf_value),
		.uniform_value(uniform_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bin_number   (bin_number),
		.bin_fraction (bin_fraction),
		.sampled_value(sampled_value)
	);

endmodule

// ===== dv/cdfs_draw_checker.sv =====
// Result checker for the CDF table inverse sampler: keeps its own copy of the
// table and grid registers, predicts each draw and compares the results.
// Depends on cdfs_pkg.
module cdfs_draw_checker #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int FRACTION_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [cdfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cdfs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            command,
	input  logic [cdfs_pkg::INDEX_W-1:0]    entry_index,
	input  logic [cdfs_pkg::CDF_W-1:0]      cdf_value,
	input  logic [cdfs_pkg::CDF_W-1:0]      uniform_value,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [cdfs_pkg::BIN_W-1:0]      bin_number,
	input  logic [cdfs_pkg::FRAC_OUT_W-1:0] bin_fraction,
	input  logic [cdfs_pkg::VALUE_W-1:0]    sampled_value,
	output int                              error_count,
	output int                              draws_pending
);

	import cdfs_pkg::*;

	typedef struct packed {
		logic [BIN_W-1:0]      bin;
		logic [FRAC_OUT_W-1:0] frac;
		logic [VALUE_W-1:0]    value;
	} draw_t;

	logic [CDF_W-1:0]  cdf_image [TABLE_ENTRIES];
	logic [BASE_W-1:0] grid_base;
	logic [STEP_W-1:0] grid_step;
	draw_t             expected_draws [$];

	// Search for the bracketing bin, interpolate inside it, map onto the grid
	function automatic draw_t predict_draw(input logic [CDF_W-1:0] u);
		int unsigned      lo;
		int unsigned      hi;
		int unsigned      mid;
		logic [CDF_W-1:0] lower;
		logic [CDF_W-1:0] upper;
		logic [63:0]      num;
		logic [63:0]      den;
		logic [63:0]      frac;
		logic [63:0]      grid;
		draw_t            d;
		lo = 0;
		hi = TABLE_ENTRIES - 1;
		while (hi - lo > 1) begin
			mid = (lo + hi) >> 1;
			if (u < cdf_image[mid]) begin
				hi = mid;
			end else begin
				lo = mid;
			end
		end
		lower = cdf_image[lo];
		upper = cdf_image[lo + 1];
		// flat or falling bin, or value at/below the lower entry
		if (upper <= lower || u <= lower) begin
			frac = '0;
		end else begin
			num  = 64'(u - lower);
			den  = 64'(upper - lower);
			// saturate when the value reaches the upper entry
			frac = (num >= den) ? (64'd1 << FRACTION_BITS) - 64'd1
			                    : (num << FRACTION_BITS) / den;
		end
		grid = (64'(grid_base) << FRACTION_BITS)
		     + 64'(grid_step) * ((64'(lo) << FRACTION_BITS) + frac);
		d.bin   = lo[BIN_W-1:0];
		d.frac  = frac[FRAC_OUT_W-1:0];
		d.value = grid[VALUE_W-1:0];
		return d;
	endfunction

	task automatic check_field(input string field, input logic [63:0] want,
	                           input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0d actual %0d",
			         $time, field, want, got);
			error_count++;
		end
	endtask

	// Track registers and table, queue predictions, compare each output transfer
	always @(posedge clk or negedge arst_n) begin
		draw_t want;
		if (!arst_n) begin
			grid_base = '0;
			grid_step = STEP_W'(1);
			expected_draws.delete();
			error_count   = 0;
			draws_pending <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_BASE_FREQUENCY: grid_base = cfg_data[BASE_W-1:0];
					REG_BIN_STEP:       grid_step = cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end
			// results first: a draw taken this cycle cannot come out this cycle
			if (out_valid && out_ready) begin
				if (expected_draws.size() == 0) begin
					$display({"%0t: result with none outstanding: expected none, ",
					          "actual bin %0d fraction %0d value %0d"},
					         $time, bin_number, bin_fraction, sampled_value);
					error_count++;
				end else begin
					want = expected_draws.pop_front();
					check_field("bin_number", 64'(want.bin), 64'(bin_number));
					check_field("bin_fraction", 64'(want.frac), 64'(bin_fraction));
					check_field("sampled_value", 64'(want.value), 64'(sampled_value));
				end
			end
			if (in_valid && in_ready) begin
				if (command == CMD_LOAD) begin
					if (entry_index < TABLE_ENTRIES)
						cdf_image[entry_index] = cdf_value;
				end else begin
					expected_draws.push_back(predict_draw(uniform_value));
				end
			end
			draws_pending <= expected_draws.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for cdf_table_inverse_sampler: clock, reset, stimulus and verdict.
// Depends on cdfs_pkg, the sampler RTL and cdfs_draw_checker.
module tb_top;
	import cdfs_pkg::*;

	localparam int TABLE_ENTRIES = 1024;
	localparam int FRACTION_BITS = 16;
	localparam int SETTLE_CYCLES = 40;    // one full draw plus margin
	localparam int QUIET_LIMIT   = 4000;
	localparam int PHASE_ITEMS   = 100;
	localparam int IDLE_PCT      = 38;
	localparam int FLAT_FIRST    = 101;   // entries 100..102 share a value

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  command;
	logic [INDEX_W-1:0]    entry_index;
	logic [CDF_W-1:0]      cdf_value;
	logic [CDF_W-1:0]      uniform_value;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [BIN_W-1:0]      bin_number;
	logic [FRAC_OUT_W-1:0] bin_fraction;
	logic [VALUE_W-1:0]    sampled_value;
	int                    error_count;
	int                    draws_pending;

	bit                    in_calm;
	bit                    out_calm;
	int                    quiet_cycles = 0;
	logic [CDF_W-1:0]      loaded_cdf [TABLE_ENTRIES];

	cdf_table_inverse_sampler #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.FRACTION_BITS(FRACTION_BITS)
	) dut (.*);

	cdfs_draw_checker #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.FRACTION_BITS(FRACTION_BITS)
	) checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result side back-pressure
	always @(posedge clk)
		out_ready <= out_calm || ($urandom_range(99) >= IDLE_PCT);

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One input transfer, with an optional random gap ahead of it
	task automatic send_item(input logic cmd, input logic [INDEX_W-1:0] idx,
	                         input logic [CDF_W-1:0] cdf, input logic [CDF_W-1:0] u);
		if (!in_calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		in_valid      <= 1'b1;
		command       <= cmd;
		entry_index   <= idx;
		cdf_value     <= cdf;
		uniform_value <= u;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic load_entry(input logic [INDEX_W-1:0] idx, input logic [CDF_W-1:0] v);
		loaded_cdf[idx] = v;
		send_item(CMD_LOAD, idx, v, $urandom);
	endtask

	task automatic draw_sample(input logic [CDF_W-1:0] u);
		send_item(CMD_SAMPLE, INDEX_W'($urandom), $urandom, u);
	endtask

	// Wait out every outstanding draw, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (draws_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_grid(input logic [CFG_DATA_W-1:0] base,
	                        input logic [CFG_DATA_W-1:0] step);
		cfg_write <= 1'b1;
		cfg_index <= REG_BASE_FREQUENCY;
		cfg_data  <= base;
		@(posedge clk);
		cfg_index <= REG_BIN_STEP;
		cfg_data  <= step;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Rising table with room below entry zero and above the last entry
	task automatic fill_table();
		logic [63:0] level;
		level = 64'h0100_0000 + $urandom_range(32'hFFFF);
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (i > 0 && i != FLAT_FIRST && i != FLAT_FIRST + 1)
				level += $urandom_range(7_000_000);
			if (level > 64'hF000_0000)
				level = 64'hF000_0000;
			load_entry(INDEX_W'(i), level[CDF_W-1:0]);
		end
	endtask

	task automatic directed_draws();
		int unsigned last;
		last = TABLE_ENTRIES - 1;
		// below, at and just above entry zero; top of range; exact hits
		draw_sample('0);
		draw_sample(loaded_cdf[0] - 1);
		draw_sample(loaded_cdf[0]);
		draw_sample(loaded_cdf[0] + 1);
		draw_sample('1);
		draw_sample(loaded_cdf[last]);
		draw_sample(loaded_cdf[last - 1]);
		draw_sample(loaded_cdf[FLAT_FIRST]);
		draw_sample(loaded_cdf[500] + (loaded_cdf[501] - loaded_cdf[500]) / 2);
		draw_sample(loaded_cdf[501] - 1);
		// flat top bin
		load_entry(INDEX_W'(last), loaded_cdf[last - 1]);
		draw_sample('1);
		// falling top bin
		load_entry(INDEX_W'(last), loaded_cdf[last - 1] - 5);
		draw_sample('1);
		draw_sample(loaded_cdf[last - 1] - 2);
		// top entry at full scale
		load_entry(INDEX_W'(last), '1);
		draw_sample(32'hFFFF_FFFE);
		draw_sample('1);
		// entry zero at zero, value exactly on it
		load_entry('0, '0);
		draw_sample('0);
		draw_sample(32'd1);
	endtask

	task automatic random_item();
		int unsigned      k;
		logic [CDF_W-1:0] lo_v;
		logic [CDF_W-1:0] hi_v;
		k = $urandom_range(TABLE_ENTRIES - 2, 1);
		if ($urandom_range(99) < 15) begin
			lo_v = loaded_cdf[k - 1];
			hi_v = loaded_cdf[k + 1];
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: begin
					// keep the table rising where the neighbors allow
					if (lo_v <= hi_v)
						load_entry(INDEX_W'(k), lo_v + $urandom_range(hi_v - lo_v));
					else
						load_entry(INDEX_W'(k), $urandom);
				end
				6, 7: load_entry(INDEX_W'(k), lo_v);
				default: load_entry(INDEX_W'($urandom_range(TABLE_ENTRIES - 1)), $urandom);
			endcase
		end else begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: draw_sample($urandom);
				6: draw_sample(loaded_cdf[k]);
				7: draw_sample($urandom_range(1) ? loaded_cdf[k] + 1 : loaded_cdf[k] - 1);
				8: draw_sample($urandom_range(1) ? '1 : '0);
				default: draw_sample(loaded_cdf[k] + $urandom_range(32'hFFFF));
			endcase
		end
	endtask

	// Stimulus and verdict
	initial begin
		arst_n        <= 1'b0;
		cfg_write     <= 1'b0;
		cfg_index     <= REG_BASE_FREQUENCY;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		command       <= CMD_LOAD;
		entry_index   <= '0;
		cdf_value     <= '0;
		uniform_value <= '0;
		in_calm  = 1'b0;
		out_calm = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset grid values first
		fill_table();
		directed_draws();

		for (int phase = 0; phase < 4; phase++) begin
			settle();
			in_calm  = 1'b0;
			out_calm = 1'b0;
			case (phase)
				0: set_grid('1, '1);
				1: begin
					// step of zero, upper data bits set; no idling anywhere
					set_grid('0, 32'hFF00_0000);
					in_calm  = 1'b1;
					out_calm = 1'b1;
				end
				2: set_grid($urandom, $urandom);
				default: set_grid($urandom, $urandom_range(255, 1));
			endcase
			repeat (PHASE_ITEMS) random_item();
		end
		settle();

		if (error_count == 0 && draws_pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
